@@ rtl/core/modbus_write_register_master_assert.svh @@
// assertion macros used by the checker file
`ifndef MODBUS_WRITE_REGISTER_MASTER_ASSERT_SVH
`define MODBUS_WRITE_REGISTER_MASTER_ASSERT_SVH

// same-cycle implication, skipped while in reset
`define MWR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, skipped while in reset
`define MWR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/mwr_pkg.sv @@
`default_nettype none
package mwr_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int FRAME_W     = 8 * FRAME_BYTES;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int CRC_BYTES   = FRAME_BYTES - 2;
  localparam int CRC_CNT_W   = $clog2(CRC_BYTES);
  localparam int HDR_W       = 8 * CRC_BYTES;

  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [15:0] TIMER_MAX         = 16'hFFFF;

  // input kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_RX    = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // output kinds
  localparam logic OUT_TX     = 1'b0;
  localparam logic OUT_STATUS = 1'b1;

  // status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_MISMATCH = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;

  // register map
  localparam logic REG_TIMEOUT  = 1'b0;
  localparam logic REG_ATTEMPTS = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET  = 16'd2000;
  localparam logic [3:0]  ATTEMPTS_RESET = 4'd3;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [15:0] timeout;
    logic [3:0]  max_attempts;
  } cfg_t;

  // one job for the back end: a whole frame or one status beat
  typedef struct packed {
    logic               is_status;
    logic [1:0]         code;
    logic [FRAME_W-1:0] frame;
  } cmd_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] crc;
  } crc_res_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/mwr_crc.sv @@
`default_nettype none
module mwr_crc (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [mwr_pkg::HDR_W-1:0] hdr,
  output mwr_pkg::crc_res_t              res
);

  logic                          busy_r, busy_nxt;
  logic [mwr_pkg::CRC_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]                   crc_r, crc_nxt;
  logic [15:0]                   crc_step;
  logic                          done;

  // one header byte per cycle
  assign crc_step = mwr_pkg::crc_byte(crc_r, hdr[8*cnt_r +: 8]);
  assign done     = busy_r && (cnt_r == mwr_pkg::CRC_CNT_W'(mwr_pkg::CRC_BYTES - 1));

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    crc_nxt  = crc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      crc_nxt  = mwr_pkg::CRC_INIT;
    end else if (busy_r) begin
      crc_nxt = crc_step;
      cnt_nxt = cnt_r + 1'b1;
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    crc_r <= crc_nxt;
  end

  assign res.busy = busy_r;
  assign res.done = done;
  assign res.crc  = crc_step;

endmodule
`default_nettype wire

@@ rtl/core/mwr_queue.sv @@
`default_nettype none
module mwr_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mwr_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output mwr_pkg::cmd_t      head,
  output logic               head_valid,
  output logic               full
);

  mwr_pkg::cmd_t               mem [mwr_pkg::Q_DEPTH];
  logic [mwr_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mwr_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mwr_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                        do_pop;

  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == mwr_pkg::Q_CNT_W'(mwr_pkg::Q_DEPTH));
  assign head       = mem[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == mwr_pkg::Q_PTR_W'(mwr_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == mwr_pkg::Q_PTR_W'(mwr_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/mwr_front.sv @@
`default_nettype none
module mwr_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [47:0]               in_tdata,
  input  wire logic [1:0]                in_tuser,
  input  wire mwr_pkg::cfg_t             cfg,
  input  wire mwr_pkg::crc_res_t         crc_res,
  output logic                           crc_start,
  output logic [mwr_pkg::HDR_W-1:0]      crc_hdr,
  input  wire logic                      q_full,
  output logic                           push,
  output mwr_pkg::cmd_t                  push_cmd
);

  logic [mwr_pkg::FRAME_W-1:0] frame_r, frame_nxt;
  logic [mwr_pkg::POS_W-1:0]   rx_pos_r, rx_pos_nxt;
  logic                        mis_r, mis_nxt;
  logic [3:0]                  attempt_r, attempt_nxt;
  logic [15:0]                 timer_r, timer_nxt;
  logic                        await_r, await_nxt;

  logic        accept;
  logic        fail;
  logic [1:0]  fail_code;
  logic        mis_c;
  logic [15:0] timer_c;
  logic [3:0]  limit;
  logic [7:0]  dev, rx;
  logic [15:0] reg_addr, reg_val;

  assign dev      = in_tdata[7:0];
  assign reg_addr = in_tdata[23:8];
  assign reg_val  = in_tdata[39:24];
  assign rx       = in_tdata[47:40];

  // hold off while the crc runs; every result-making beat needs one queue slot
  assign in_tready = !crc_res.busy && !q_full;
  assign accept    = in_tvalid && in_tready;
  assign crc_hdr   = frame_r[mwr_pkg::HDR_W-1:0];
  assign limit     = (cfg.max_attempts == 4'd0) ? 4'd1 : cfg.max_attempts;

  always_comb begin
    frame_nxt   = frame_r;
    rx_pos_nxt  = rx_pos_r;
    mis_nxt     = mis_r;
    attempt_nxt = attempt_r;
    timer_nxt   = timer_r;
    await_nxt   = await_r;
    crc_start   = 1'b0;
    push        = 1'b0;
    push_cmd    = '{is_status: 1'b0, code: mwr_pkg::STATUS_OK, frame: frame_r};
    fail        = 1'b0;
    fail_code   = mwr_pkg::STATUS_MISMATCH;
    mis_c       = mis_r | (frame_r[8*rx_pos_r +: 8] != rx);
    timer_c     = (timer_r != mwr_pkg::TIMER_MAX) ? timer_r + 16'd1 : timer_r;

    if (crc_res.done) begin
      frame_nxt[mwr_pkg::FRAME_W-1:mwr_pkg::HDR_W] = crc_res.crc;
      push           = 1'b1;
      push_cmd.frame = {crc_res.crc, frame_r[mwr_pkg::HDR_W-1:0]};
    end

    if (accept) begin
      case (in_tuser)
        mwr_pkg::KIND_START: begin
          frame_nxt[mwr_pkg::HDR_W-1:0] = {reg_val[7:0], reg_val[15:8], reg_addr[7:0],
                                           reg_addr[15:8], mwr_pkg::FUNC_WRITE_SINGLE, dev};
          attempt_nxt = 4'd1;
          rx_pos_nxt  = '0;
          mis_nxt     = 1'b0;
          timer_nxt   = '0;
          await_nxt   = 1'b1;
          crc_start   = 1'b1;
        end
        mwr_pkg::KIND_RX: begin
          if (await_r) begin
            if (rx_pos_r == mwr_pkg::POS_W'(mwr_pkg::FRAME_BYTES - 1)) begin
              if (!mis_c) begin
                await_nxt  = 1'b0;
                rx_pos_nxt = '0;
                mis_nxt    = 1'b0;
                timer_nxt  = '0;
                push       = 1'b1;
                push_cmd   = '{is_status: 1'b1, code: mwr_pkg::STATUS_OK, frame: frame_r};
              end else begin
                fail      = 1'b1;
                fail_code = mwr_pkg::STATUS_MISMATCH;
              end
            end else begin
              rx_pos_nxt = rx_pos_r + 1'b1;
              mis_nxt    = mis_c;
            end
          end
        end
        mwr_pkg::KIND_TICK: begin
          if (await_r) begin
            timer_nxt = timer_c;
            if (timer_c >= cfg.timeout) begin
              fail      = 1'b1;
              fail_code = mwr_pkg::STATUS_TIMEOUT;
            end
          end
        end
        default: ;
      endcase
    end

    // attempt over: resend while attempts remain, else report
    if (fail) begin
      rx_pos_nxt = '0;
      mis_nxt    = 1'b0;
      timer_nxt  = '0;
      push       = 1'b1;
      if (attempt_r < limit) begin
        attempt_nxt = attempt_r + 4'd1;
        await_nxt   = 1'b1;
        push_cmd    = '{is_status: 1'b0, code: mwr_pkg::STATUS_OK, frame: frame_r};
      end else begin
        await_nxt = 1'b0;
        push_cmd  = '{is_status: 1'b1, code: fail_code, frame: frame_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_pos_r  <= '0;
      mis_r     <= 1'b0;
      attempt_r <= '0;
      timer_r   <= '0;
      await_r   <= 1'b0;
    end else begin
      rx_pos_r  <= rx_pos_nxt;
      mis_r     <= mis_nxt;
      attempt_r <= attempt_nxt;
      timer_r   <= timer_nxt;
      await_r   <= await_nxt;
    end
    frame_r <= frame_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/core/mwr_back.sv @@
`default_nettype none
module mwr_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mwr_pkg::cmd_t head,
  input  wire logic          head_valid,
  output logic               pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [15:0]        out_tdata,
  output logic               out_tlast,
  output logic [0:0]         out_tuser
);

  mwr_pkg::cmd_t             cur_r, cur_nxt;
  logic                      busy_r, busy_nxt;
  logic [mwr_pkg::POS_W-1:0] idx_r, idx_nxt;
  logic                      vld_r, vld_nxt;
  logic [7:0]                tx_r, tx_nxt;
  logic [1:0]                st_r, st_nxt;
  logic                      last_r, last_nxt;
  logic                      kind_r, kind_nxt;

  logic       adv;
  logic       beat_last;
  logic [7:0] beat_tx;

  assign adv       = busy_r && (!vld_r || out_tready);
  assign beat_last = cur_r.is_status || (idx_r == mwr_pkg::POS_W'(mwr_pkg::FRAME_BYTES - 1));
  assign beat_tx   = cur_r.is_status ? 8'h00 : cur_r.frame[8*idx_r +: 8];
  // next job loads when idle, or as the last beat of the current one is registered
  assign pop       = head_valid && (!busy_r || (adv && beat_last));

  always_comb begin
    cur_nxt  = cur_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    vld_nxt  = vld_r && !out_tready;
    tx_nxt   = tx_r;
    st_nxt   = st_r;
    last_nxt = last_r;
    kind_nxt = kind_r;
    if (adv) begin
      vld_nxt  = 1'b1;
      tx_nxt   = beat_tx;
      st_nxt   = cur_r.is_status ? cur_r.code : mwr_pkg::STATUS_OK;
      last_nxt = beat_last;
      kind_nxt = cur_r.is_status ? mwr_pkg::OUT_STATUS : mwr_pkg::OUT_TX;
      idx_nxt  = idx_r + 1'b1;
      if (beat_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (pop) begin
      cur_nxt  = head;
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      vld_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      vld_r  <= vld_nxt;
    end
    cur_r  <= cur_nxt;
    tx_r   <= tx_nxt;
    st_r   <= st_nxt;
    last_r <= last_nxt;
    kind_r <= kind_nxt;
  end

  assign out_tvalid   = vld_r;
  assign out_tdata    = {6'b0, st_r, tx_r};
  assign out_tlast    = last_r;
  assign out_tuser[0] = kind_r;

endmodule
`default_nettype wire

@@ rtl/core/modbus_write_register_master.sv @@
// channel   dir  handshake             payload
// in_       in   in_tvalid/in_tready   tdata: device, register, value, rx byte; tuser: kind
// out_      out  out_tvalid/out_tready tdata: tx byte, status; tuser: kind; tlast
// cfg_      in   apb, pready high      0x0 response timeout ticks, 0x4 max attempts
//
// after a start beat the crc unit folds one header byte per cycle while input is held off
// received-byte and tick beats are taken every cycle while the job queue has room and the crc unit is idle
// each start or retry sends 8 out beats, one per cycle while out_tready is high; a final status is 1 beat
// a two-entry job queue lets input continue while output is stalled
// synchronous active-low reset clears control state and loads the register defaults
`default_nettype none
module modbus_write_register_master (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // device_address, register_address, register_value, rx_byte
  input  wire logic [1:0]  in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // tx_byte, status, zero pad
  output logic             out_tlast,
  output logic [0:0]       out_tuser,  // out_kind
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  mwr_pkg::cfg_t     cfg_r, cfg_nxt;
  mwr_pkg::crc_res_t crc_res;
  mwr_pkg::cmd_t     push_cmd, head;
  logic              cfg_wr;
  logic              crc_start;
  logic [mwr_pkg::HDR_W-1:0] crc_hdr;
  logic              push, pop, head_valid, q_full;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        mwr_pkg::REG_TIMEOUT:  cfg_nxt.timeout      = cfg_pwdata[15:0];
        mwr_pkg::REG_ATTEMPTS: cfg_nxt.max_attempts = cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      mwr_pkg::REG_TIMEOUT:  cfg_prdata = {16'b0, cfg_r.timeout};
      mwr_pkg::REG_ATTEMPTS: cfg_prdata = {28'b0, cfg_r.max_attempts};
      default:               cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{timeout: mwr_pkg::TIMEOUT_RESET, max_attempts: mwr_pkg::ATTEMPTS_RESET};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mwr_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (crc_start),
    .hdr   (crc_hdr),
    .res   (crc_res)
  );

  mwr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg_r),
    .crc_res   (crc_res),
    .crc_start (crc_start),
    .crc_hdr   (crc_hdr),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  mwr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  mwr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

@@ rtl/core/mwr_checker.sv @@
`default_nettype none
`include "modbus_write_register_master_assert.svh"
module mwr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic [0:0]  out_tuser
);

  // a stalled beat holds
  `MWR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))

  // a status beat closes its run
  `MWR_ASSERT_IMPL(a_status_last, out_tvalid && (out_tuser[0] == mwr_pkg::OUT_STATUS), out_tlast)

  // status beats carry no byte and a known code
  `MWR_ASSERT_IMPL(a_status_clean, out_tvalid && (out_tuser[0] == mwr_pkg::OUT_STATUS), (out_tdata[7:0] == 8'h00) && (out_tdata[9:8] <= mwr_pkg::STATUS_TIMEOUT))

  // transmit beats carry a zero status and no pad bits
  `MWR_ASSERT_IMPL(a_tx_clean, out_tvalid && (out_tuser[0] == mwr_pkg::OUT_TX), out_tdata[15:8] == 8'h00)

endmodule

bind modbus_write_register_master mwr_checker u_mwr_checker (.*);
`default_nettype wire

@@ tb/modbus_write_register_master_tb.sv @@
module modbus_write_register_master_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 16;

  typedef struct {
    logic       okind;
    logic [7:0] tx;
    logic       last;
    logic [1:0] status;
  } out_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // device_address, register_address, register_value, rx_byte
  logic [1:0]  in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // tx_byte, status, zero pad
  logic        out_tlast;
  logic [0:0]  out_tuser;  // out_kind
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  modbus_write_register_master u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // master state as predicted
  logic [7:0]  req_bytes [0:7];
  logic [3:0]  echo_pos;
  logic        echo_bad;
  logic [3:0]  sends_made;
  logic [15:0] ticks_seen;
  logic        in_write;
  logic [15:0] lim_ticks;
  logic [3:0]  lim_sends;

  out_beat_t due_beats [$];

  int error_count;
  int fed_items;
  bit idle_on;
  bit stall_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic void due_add(input logic okind, input logic [7:0] tx,
                                  input logic last, input logic [1:0] status);
    out_beat_t b;
    b.okind = okind;
    b.tx = tx;
    b.last = last;
    b.status = status;
    due_beats.insert(due_beats.size(), b);
  endfunction

  function automatic logic [15:0] header_crc();
    logic [15:0] c;
    c = mwr_pkg::CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      c ^= {8'h00, req_bytes[i]};
      for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ mwr_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void queue_frame();
    sends_made = sends_made + 4'd1;
    echo_pos = 4'd0;
    echo_bad = 1'b0;
    ticks_seen = 16'd0;
    in_write = 1'b1;
    for (int i = 0; i < 8; i++)
      due_add(mwr_pkg::OUT_TX, req_bytes[i], i == 7, mwr_pkg::STATUS_OK);
  endfunction

  function automatic void attempt_over(input logic [1:0] code);
    logic [3:0] lim;
    lim = (lim_sends == 4'd0) ? 4'd1 : lim_sends;
    if (sends_made < lim) begin
      queue_frame();
    end else begin
      in_write = 1'b0;
      echo_pos = 4'd0;
      echo_bad = 1'b0;
      ticks_seen = 16'd0;
      due_add(mwr_pkg::OUT_STATUS, 8'h00, 1'b1, code);
    end
  endfunction

  // returns 1 when the beat is not simply dropped by the master
  function automatic bit advance_master(input logic [1:0] kind, input logic [7:0] dev,
                                        input logic [15:0] regn, input logic [15:0] val,
                                        input logic [7:0] rxb);
    logic [15:0] crc;
    if (kind == mwr_pkg::KIND_START) begin
      req_bytes[0] = dev;
      req_bytes[1] = mwr_pkg::FUNC_WRITE_SINGLE;
      req_bytes[2] = regn[15:8];
      req_bytes[3] = regn[7:0];
      req_bytes[4] = val[15:8];
      req_bytes[5] = val[7:0];
      crc = header_crc();
      req_bytes[6] = crc[7:0];
      req_bytes[7] = crc[15:8];
      sends_made = 4'd0;
      queue_frame();
      return 1'b1;
    end
    if (!in_write) return 1'b0;
    if (kind == mwr_pkg::KIND_RX) begin
      if (echo_pos < 4'd8 && req_bytes[echo_pos[2:0]] != rxb) echo_bad = 1'b1;
      echo_pos = echo_pos + 4'd1;
      if (echo_pos < 4'd8) return 1'b1;
      if (!echo_bad) begin
        in_write = 1'b0;
        echo_pos = 4'd0;
        ticks_seen = 16'd0;
        due_add(mwr_pkg::OUT_STATUS, 8'h00, 1'b1, mwr_pkg::STATUS_OK);
      end else begin
        attempt_over(mwr_pkg::STATUS_MISMATCH);
      end
      return 1'b1;
    end
    if (kind == mwr_pkg::KIND_TICK) begin
      if (ticks_seen != 16'hFFFF) ticks_seen = ticks_seen + 16'd1;
      // a zero limit fires on the first tick
      if (ticks_seen >= lim_ticks) attempt_over(mwr_pkg::STATUS_TIMEOUT);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(negedge clk) out_tready <= !(stall_on && $urandom_range(0, 99) < 30);

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected out beat kind %0d data %h",
                                  out_tuser[0], out_tdata));
      end else begin
        want = due_beats.pop_front();
        if (out_tuser[0] !== want.okind)
          report_mismatch($sformatf("out kind %b, want %b", out_tuser[0], want.okind));
        if (out_tdata[7:0] !== want.tx)
          report_mismatch($sformatf("tx byte %h, want %h", out_tdata[7:0], want.tx));
        if (out_tdata[9:8] !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_tdata[9:8], want.status));
        if (out_tdata[15:10] !== 6'd0)
          report_mismatch($sformatf("pad bits %b not zero", out_tdata[15:10]));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("tlast %b, want %b", out_tlast, want.last));
      end
    end
  end

  task automatic send_beat(input logic [1:0] kind, input logic [7:0] dev,
                           input logic [15:0] regn, input logic [15:0] val,
                           input logic [7:0] rxb);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {rxb, val, regn, dev};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    if (advance_master(kind, dev, regn, val, rxb)) fed_items++;
  endtask

  task automatic send_start(input logic [7:0] dev, input logic [15:0] regn,
                            input logic [15:0] val);
    send_beat(mwr_pkg::KIND_START, dev, regn, val, 8'($urandom));
  endtask

  task automatic send_rx(input logic [7:0] b);
    send_beat(mwr_pkg::KIND_RX, 8'($urandom), 16'($urandom), 16'($urandom), b);
  endtask

  task automatic send_tick();
    send_beat(mwr_pkg::KIND_TICK, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic send_random_kind();
    send_beat(2'($urandom_range(KIND_UNUSED, mwr_pkg::KIND_RX)), 8'($urandom),
              16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic send_random_start();
    send_start(8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // echo the rest of the stored frame with random ticks mixed in, corrupting the byte at offset bad_k of the rest
  task automatic send_echo(input int bad_k, input int tick_pct);
    int n;
    logic [7:0] b;
    logic [7:0] flip;
    n = 8 - echo_pos;
    flip = 8'($urandom_range(1, 255));
    for (int k = 0; k < n; k++) begin
      if (tick_pct > 0 && $urandom_range(0, 99) < tick_pct) send_tick();
      b = req_bytes[echo_pos[2:0]];
      if (k == bad_k) b = b ^ flip;
      send_rx(b);
    end
  endtask

  task automatic finish_write();
    while (in_write) send_rx(req_bytes[echo_pos[2:0]]);
  endtask

  task automatic settle();
    int waited;
    @(negedge clk);
    in_tvalid <= 1'b0;
    waited = 0;
    while (due_beats.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    if (due_beats.size() != 0) begin
      report_mismatch($sformatf("%0d out beats never came", due_beats.size()));
      due_beats.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write followed by a read back of the same register
  task automatic cfg_write(input logic idx, input logic [15:0] value);
    logic [31:0] mask;
    mask = (idx == mwr_pkg::REG_TIMEOUT) ? 32'h0000_FFFF : 32'h0000_000F;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {16'h0000, value} & mask;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    if (idx == mwr_pkg::REG_TIMEOUT) lim_ticks = value;
    else lim_sends = value[3:0];
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    if ((cfg_prdata & mask) !== ({16'h0000, value} & mask))
      report_mismatch($sformatf("register %0d reads %h, want %h", idx, cfg_prdata,
                                {16'h0000, value} & mask));
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic test_idle_beats();
    send_rx(8'hFF);
    send_tick();
    send_beat(KIND_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
  endtask

  task automatic test_restart_and_retry();
    send_start(8'hFF, 16'hFFFF, 16'h0000);
    send_beat(KIND_UNUSED, 8'h00, 16'h0000, 16'h0000, 8'h00);
    // second start drops the first write without a status
    send_start(8'h00, 16'h0000, 16'hFFFF);
    // bad crc low byte in the echo
    send_echo(6, 0);
    send_echo(8, 0);
    settle();
  endtask

  task automatic test_zero_limits();
    cfg_write(mwr_pkg::REG_TIMEOUT, 16'd0);
    cfg_write(mwr_pkg::REG_ATTEMPTS, 16'd0);
    send_random_start();
    send_tick();
    settle();
  endtask

  task automatic test_random_traffic(input logic [15:0] t_lim, input logic [3:0] a_lim,
                                     input int goal, input bit with_gaps);
    int r;
    int n;
    cfg_write(mwr_pkg::REG_TIMEOUT, t_lim);
    cfg_write(mwr_pkg::REG_ATTEMPTS, {12'd0, a_lim});
    idle_on = with_gaps;
    stall_on = with_gaps;
    fed_items = 0;
    while (fed_items < goal) begin
      r = $urandom_range(0, 99);
      if (!in_write) begin
        if (r < 10) send_random_kind();
        else send_random_start();
      end else if (r < 45) begin
        send_echo(8, 8);
      end else if (r < 65) begin
        send_echo($urandom_range(0, 7 - echo_pos), 0);
      end else if (r < 80) begin
        n = ((lim_ticks == 16'd0) ? 1 : lim_ticks) - ticks_seen;
        if (n > 64) n = $urandom_range(1, 5);
        repeat (n) send_tick();
      end else if (r < 92) begin
        send_random_kind();
      end else begin
        send_random_start();
      end
    end
    finish_write();
    settle();
    idle_on = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    idle_on = 1'b1;
    stall_on = 1'b1;
    error_count = 0;
    fed_items = 0;
    for (int i = 0; i < 8; i++) req_bytes[i] = 8'h00;
    echo_pos = 4'd0;
    echo_bad = 1'b0;
    sends_made = 4'd0;
    ticks_seen = 16'd0;
    in_write = 1'b0;
    lim_ticks = mwr_pkg::TIMEOUT_RESET;
    lim_sends = mwr_pkg::ATTEMPTS_RESET;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_beats();
    test_restart_and_retry();
    test_zero_limits();
    test_random_traffic(16'd1, 4'd1, 65, 1'b1);
    test_random_traffic(16'd7, 4'd4, 65, 1'b1);
    test_random_traffic(16'hFFFF, 4'd15, 65, 1'b0);
    test_random_traffic(16'($urandom_range(2, 40)), 4'($urandom_range(1, 15)), 70, 1'b1);

    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ modbus_write_register_master.f @@
+incdir+rtl/core
rtl/core/mwr_pkg.sv
rtl/core/mwr_crc.sv
rtl/core/mwr_queue.sv
rtl/core/mwr_front.sv
rtl/core/mwr_back.sv
rtl/core/modbus_write_register_master.sv
rtl/core/mwr_checker.sv
tb/modbus_write_register_master_tb.sv
